// File: hdl/flsc_pkg.sv
// shared types, token and status codes and grammar helpers of the formula checker
package flsc_pkg;

   localparam logic [3:0] KIND_INT32    = 4'd0;
   localparam logic [3:0] KIND_INT64    = 4'd1;
   localparam logic [3:0] KIND_FLOAT32  = 4'd2;
   localparam logic [3:0] KIND_FLOAT64  = 4'd3;
   localparam logic [3:0] KIND_STRING   = 4'd4;
   localparam logic [3:0] KIND_BOOLEAN  = 4'd5;
   localparam logic [3:0] KIND_COLUMN   = 4'd6;
   localparam logic [3:0] KIND_FUNCTION = 4'd7;
   localparam logic [3:0] KIND_COMMA    = 4'd8;
   localparam logic [3:0] KIND_OPEN     = 4'd9;
   localparam logic [3:0] KIND_CLOSE    = 4'd10;
   localparam logic [3:0] KIND_INVALID  = 4'd11;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_UNTERM     = 3'd1;
   localparam logic [2:0] STATUS_INVALID    = 3'd2;
   localparam logic [2:0] STATUS_EMPTY      = 3'd3;
   localparam logic [2:0] STATUS_LONE       = 3'd4;
   localparam logic [2:0] STATUS_FIRST_FUNC = 3'd5;
   localparam logic [2:0] STATUS_SYNTAX     = 3'd6;

   // one accepted character as seen by the grammar side
   typedef struct packed {
      logic [1:0] tok_count;
      logic [3:0] kind0;
      logic [3:0] kind1;
      logic       fin;
      logic       unterm;
   } bundle_type;

   function automatic logic allowed(input logic [3:0] prev, input logic [3:0] next);
      logic ok;
      ok = 1'b1;
      if (prev <= KIND_COLUMN) ok = (next == KIND_COMMA) || (next == KIND_CLOSE);
      else if (prev == KIND_FUNCTION) ok = (next == KIND_OPEN);
      else if (prev == KIND_COMMA) ok = (next <= KIND_FUNCTION);
      else if (prev == KIND_OPEN) ok = (next <= KIND_FUNCTION) || (next == KIND_CLOSE);
      else if (prev == KIND_CLOSE)
         ok = (next == KIND_COMMA) || (next == KIND_CLOSE) || (next == KIND_INVALID);
      return ok;
   endfunction

endpackage

// File: hdl/flsc_front.sv
// lexer front end: splits characters into tokens and classifies them
module flsc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          char_code,
   input  logic                is_final,
   output logic                has_results,
   output flsc_pkg::bundle_type bundle
);

   localparam logic [3:0] LS_START  = 4'd0;
   localparam logic [3:0] LS_MINUS  = 4'd1;
   localparam logic [3:0] LS_INT    = 4'd2;
   localparam logic [3:0] LS_INT64  = 4'd3;
   localparam logic [3:0] LS_DOT    = 4'd4;
   localparam logic [3:0] LS_FRAC   = 4'd5;
   localparam logic [3:0] LS_F32    = 4'd6;
   localparam logic [3:0] LS_DOLLAR = 4'd7;
   localparam logic [3:0] LS_COLUMN = 4'd8;
   localparam logic [3:0] LS_IDENT  = 4'd9;
   localparam logic [3:0] LS_BAD    = 4'd10;
   localparam logic [3:0] LS_STR    = 4'd11;
   localparam logic [3:0] LS_STR_BAD = 4'd12;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;

   logic       ins_ff, ins_in;
   logic [3:0] ls_ff, ls_in;
   logic [3:0] kw_ff, kw_in;
   logic       pend_ff, pend_in;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == 8'h5f);
   endfunction

   function automatic logic [3:0] next_kw(input logic [3:0] p, input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      case (p)
         4'd1: if (c == 8'h72) n = 4'd2;
         4'd2: if (c == 8'h75) n = 4'd3;
         4'd3: if (c == 8'h65) n = 4'd4;
         4'd5: if (c == 8'h61) n = 4'd6;
         4'd6: if (c == 8'h6c) n = 4'd7;
         4'd7: if (c == 8'h73) n = 4'd8;
         4'd8: if (c == 8'h65) n = 4'd9;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] classify(input logic [3:0] s, input logic [3:0] kw);
      logic [3:0] k;
      case (s)
         LS_INT:          k = flsc_pkg::KIND_INT32;
         LS_INT64:        k = flsc_pkg::KIND_INT64;
         LS_DOT, LS_FRAC: k = flsc_pkg::KIND_FLOAT64;
         LS_F32:          k = flsc_pkg::KIND_FLOAT32;
         LS_COLUMN:       k = flsc_pkg::KIND_COLUMN;
         LS_IDENT: k = (kw == 4'd4 || kw == 4'd9) ? flsc_pkg::KIND_BOOLEAN
                                                  : flsc_pkg::KIND_FUNCTION;
         default:         k = flsc_pkg::KIND_INVALID;
      endcase
      return k;
   endfunction

   always_comb begin
      logic [3:0] kinds [2];
      logic [1:0] tn;
      logic       unterm;
      ins_in   = ins_ff;
      ls_in    = ls_ff;
      kw_in    = kw_ff;
      pend_in  = pend_ff;
      kinds[0] = flsc_pkg::KIND_INT32;
      kinds[1] = flsc_pkg::KIND_INT32;
      tn       = 2'd0;
      unterm   = 1'b0;

      if (ins_ff) begin
         if (char_code == CH_QUOTE) begin
            kinds[0] = (ls_ff == LS_STR_BAD) ? flsc_pkg::KIND_INVALID : flsc_pkg::KIND_STRING;
            tn       = 2'd1;
            ins_in   = 1'b0;
            ls_in    = LS_START;
            pend_in  = 1'b0;
         end else if (char_code == CH_CR || char_code == CH_LF) begin
            ls_in = LS_STR_BAD;
         end
      end else if (char_code inside {CH_QUOTE, CH_SPACE, CH_COMMA, CH_OPEN, CH_CLOSE}) begin
         // delimiter: flush any pending plain token first
         if (pend_ff) begin
            kinds[0] = classify(ls_ff, kw_ff);
            tn       = 2'd1;
         end
         ls_in   = LS_START;
         kw_in   = 4'd0;
         pend_in = 1'b0;
         if (char_code == CH_QUOTE) begin
            ins_in  = 1'b1;
            ls_in   = LS_STR;
            pend_in = 1'b1;
         end else if (char_code != CH_SPACE) begin
            kinds[tn[0]] = (char_code == CH_COMMA) ? flsc_pkg::KIND_COMMA :
                           (char_code == CH_OPEN)  ? flsc_pkg::KIND_OPEN  :
                                                     flsc_pkg::KIND_CLOSE;
            tn = tn + 2'd1;
         end
      end else begin
         ls_in   = LS_BAD;
         pend_in = 1'b1;
         case (ls_ff)
            LS_START: begin
               if (char_code == 8'h2d) ls_in = LS_MINUS;
               else if (is_digit(char_code)) ls_in = LS_INT;
               else if (char_code == 8'h24) ls_in = LS_DOLLAR;
               else if (is_alpha(char_code)) begin
                  ls_in = LS_IDENT;
                  kw_in = (char_code == 8'h54) ? 4'd1 : (char_code == 8'h46) ? 4'd5 : 4'd0;
               end
            end
            LS_MINUS: if (is_digit(char_code)) ls_in = LS_INT;
            LS_INT: begin
               if (is_digit(char_code)) ls_in = LS_INT;
               else if (char_code == 8'h6c || char_code == 8'h4c) ls_in = LS_INT64;
               else if (char_code == 8'h2e) ls_in = LS_DOT;
            end
            LS_DOT, LS_FRAC: begin
               if (is_digit(char_code)) ls_in = LS_FRAC;
               else if (char_code == 8'h66) ls_in = LS_F32;
            end
            LS_DOLLAR: if (is_alpha(char_code) || char_code == 8'h5f) ls_in = LS_COLUMN;
            LS_COLUMN: if (is_word(char_code)) ls_in = LS_COLUMN;
            LS_IDENT: begin
               if (is_word(char_code)) begin
                  ls_in = LS_IDENT;
                  kw_in = next_kw(kw_ff, char_code);
               end
            end
            default: ls_in = LS_BAD;
         endcase
      end

      if (is_final) begin
         // implied trailing space, then back to the reset state
         if (!ins_in && pend_in) begin
            kinds[tn[0]] = classify(ls_in, kw_in);
            tn = tn + 2'd1;
         end
         unterm  = ins_in;
         ins_in  = 1'b0;
         ls_in   = LS_START;
         kw_in   = 4'd0;
         pend_in = 1'b0;
      end

      bundle.tok_count = tn;
      bundle.kind0     = kinds[0];
      bundle.kind1     = kinds[1];
      bundle.fin       = is_final;
      bundle.unterm    = unterm;
      has_results      = is_final || (tn != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff  <= 1'b0;
         ls_ff   <= LS_START;
         kw_ff   <= 4'd0;
         pend_ff <= 1'b0;
      end else if (push) begin
         ins_ff  <= ins_in;
         ls_ff   <= ls_in;
         kw_ff   <= kw_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: hdl/flsc_queue.sv
// two-entry queue of character bundles between lexer and grammar checker
module flsc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  flsc_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output flsc_pkg::bundle_type head
);

   flsc_pkg::bundle_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// File: hdl/flsc_back.sv
// grammar back end: checks tokens and drives one beat a cycle unless stalled
module flsc_back #(
   parameter int MAX_DEPTH = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  flsc_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_status,
   output logic [3:0]          rsp_token_kind,
   output logic [2:0]          rsp_status_code,
   output logic                rsp_run_end
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

   logic          valid_ff;
   logic          is_status_ff;
   logic [3:0]    kind_ff;
   logic [2:0]    status_ff;
   logic          run_end_ff;

   logic [1:0]    idx_ff, idx_in;
   logic [1:0]    seen_ff, seen_in;
   logic [3:0]    first_ff, first_in;
   logic [3:0]    prev_ff, prev_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic          opened_ff, opened_in;
   logic          ctz_ff, ctz_in;
   logic          bad_ff, bad_in;
   logic          inv_ff, inv_in;

   logic          load;
   logic          is_tok;
   logic          last;
   logic [1:0]    n_res;
   logic [3:0]    kind;
   logic [2:0]    status;

   assign load   = head_valid && (!valid_ff || rsp_ready);
   assign n_res  = head.tok_count + {1'b0, head.fin};
   assign is_tok = idx_ff < head.tok_count;
   assign last   = (idx_ff == n_res - 2'd1);
   assign kind   = (idx_ff == 2'd0) ? head.kind0 : head.kind1;
   assign pop    = load && last;

   always_comb begin
      if (head.unterm) status = flsc_pkg::STATUS_UNTERM;
      else if (inv_ff) status = flsc_pkg::STATUS_INVALID;
      else if (seen_ff == 2'd0) status = flsc_pkg::STATUS_EMPTY;
      else if (seen_ff == 2'd1)
         status = (first_ff <= flsc_pkg::KIND_COLUMN) ? flsc_pkg::STATUS_OK
                                                      : flsc_pkg::STATUS_LONE;
      else if (first_ff != flsc_pkg::KIND_FUNCTION) status = flsc_pkg::STATUS_FIRST_FUNC;
      else if (bad_ff || depth_ff != '0) status = flsc_pkg::STATUS_SYNTAX;
      else status = flsc_pkg::STATUS_OK;
   end

   always_comb begin
      idx_in    = idx_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      prev_in   = prev_ff;
      depth_in  = depth_ff;
      opened_in = opened_ff;
      ctz_in    = ctz_ff;
      bad_in    = bad_ff;
      inv_in    = inv_ff;
      if (load) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
         if (is_tok) begin
            if (kind == flsc_pkg::KIND_INVALID) inv_in = 1'b1;
            if (seen_ff == 2'd0) first_in = kind;
            else if (!bad_ff && (ctz_ff || !flsc_pkg::allowed(prev_ff, kind))) bad_in = 1'b1;
            if (!bad_in) begin
               if (kind == flsc_pkg::KIND_OPEN) begin
                  if (depth_ff >= DEPTH_MAX) bad_in = 1'b1;
                  else begin
                     depth_in  = depth_ff + 1'b1;
                     opened_in = 1'b1;
                  end
               end else if (kind == flsc_pkg::KIND_CLOSE) begin
                  if (depth_ff == '0) bad_in = 1'b1;
                  else begin
                     depth_in = depth_ff - 1'b1;
                     if (depth_in == '0 && opened_ff) ctz_in = 1'b1;
                  end
               end
            end
            prev_in = kind;
            if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
         end else begin
            // status beat closes the formula
            seen_in   = 2'd0;
            first_in  = flsc_pkg::KIND_INT32;
            prev_in   = flsc_pkg::KIND_INT32;
            depth_in  = '0;
            opened_in = 1'b0;
            ctz_in    = 1'b0;
            bad_in    = 1'b0;
            inv_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         is_status_ff <= !is_tok;
         kind_ff      <= is_tok ? kind : flsc_pkg::KIND_INT32;
         status_ff    <= is_tok ? flsc_pkg::STATUS_OK : status;
         run_end_ff   <= last;
      end
      if (reset) begin
         valid_ff  <= 1'b0;
         idx_ff    <= 2'd0;
         seen_ff   <= 2'd0;
         first_ff  <= flsc_pkg::KIND_INT32;
         prev_ff   <= flsc_pkg::KIND_INT32;
         depth_ff  <= '0;
         opened_ff <= 1'b0;
         ctz_ff    <= 1'b0;
         bad_ff    <= 1'b0;
         inv_ff    <= 1'b0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
         idx_ff    <= idx_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         prev_ff   <= prev_in;
         depth_ff  <= depth_in;
         opened_ff <= opened_in;
         ctz_ff    <= ctz_in;
         bad_ff    <= bad_in;
         inv_ff    <= inv_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_is_status   = is_status_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_status_code = status_ff;
   assign rsp_run_end     = run_end_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX) else $error("paren depth past limit");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < n_res) else $error("result index past bundle");
   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      load && !is_tok |=> seen_ff == 2'd0 && depth_ff == '0 && !bad_ff)
      else $error("grammar state not cleared after status");
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == 2'd0) else $error("index left over with empty queue");

endmodule

// File: hdl/formula_lexer_syntax_checker.sv
// top level of the formula lexer and syntax checker
// a character's results pass the bundle queue and then the output register
// throughput: one character a cycle in, one result beat a cycle out, when not stalled;
//   a character's k results hold the grammar stage (k up to 3 on a final close)
// a two-entry bundle queue parts the lexer from the grammar stage
// reset: synchronous, active high; clears lexer, queue, grammar state and output valid
module formula_lexer_syntax_checker #(
   parameter int MAX_DEPTH = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_status,
   output logic [3:0] rsp_token_kind,
   output logic [2:0] rsp_status_code,
   output logic       rsp_run_end
);

   // front side
   logic                 accept;
   logic                 has_results;
   flsc_pkg::bundle_type bundle;

   // queue side
   logic                 q_full;
   logic                 q_not_empty;
   logic                 q_pop;
   flsc_pkg::bundle_type q_head;

   // a beat is taken whenever the queue has room, whatever the output does
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   flsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .char_code   (req_char_code),
      .is_final    (req_is_final),
      .has_results (has_results),
      .bundle      (bundle)
   );

   // characters that only extend a token produce nothing and skip the queue
   flsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && has_results),
      .push_data (bundle),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   flsc_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_not_empty),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_status   (rsp_is_status),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_status_code (rsp_status_code),
      .rsp_run_end     (rsp_run_end)
   );

endmodule

// File: sim/tb_formula_lexer_syntax_checker.sv
// testbench of the formula lexer and syntax checker: random and directed formulas, scoreboard
module tb_formula_lexer_syntax_checker;

   typedef struct packed {
      logic       is_status;
      logic [3:0] kind;
      logic [2:0] status;
      logic       run_end;
   } beat_type;

   localparam logic [3:0] LX_START  = 4'd0;
   localparam logic [3:0] LX_MINUS  = 4'd1;
   localparam logic [3:0] LX_INT    = 4'd2;
   localparam logic [3:0] LX_INT64  = 4'd3;
   localparam logic [3:0] LX_DOT    = 4'd4;
   localparam logic [3:0] LX_FRAC   = 4'd5;
   localparam logic [3:0] LX_F32    = 4'd6;
   localparam logic [3:0] LX_DOLLAR = 4'd7;
   localparam logic [3:0] LX_COLUMN = 4'd8;
   localparam logic [3:0] LX_IDENT  = 4'd9;
   localparam logic [3:0] LX_BAD    = 4'd10;
   localparam logic [3:0] LX_STR    = 4'd11;
   localparam logic [3:0] LX_STR_BAD = 4'd12;
   localparam int DEPTH_LIMIT = 255;
   localparam int CYCLE_LIMIT = 200000;

   // scoreboard: own copy of the formula checker state and a queue of expected beats
   class formula_scoreboard;
      bit       in_str;
      bit [3:0] lx;
      bit [3:0] kw;
      bit       pend;
      bit [1:0] ntok;
      bit [3:0] first_k, prev_k;
      int       depth;
      bit       opened, back_to_zero, grammar_bad, saw_invalid;
      beat_type pending_beats[$];
      int       errors, tokens, statuses;

      function void clear();
         in_str = 0; lx = LX_START; kw = 0; pend = 0; ntok = 0;
         first_k = 0; prev_k = 0; depth = 0; opened = 0; back_to_zero = 0;
         grammar_bad = 0; saw_invalid = 0;
      endfunction

      function bit digit(bit [7:0] c); return c >= "0" && c <= "9"; endfunction
      function bit alpha(bit [7:0] c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction
      function bit wordc(bit [7:0] c); return alpha(c) || digit(c) || c == "_"; endfunction

      function bit may_follow(bit [3:0] p, bit [3:0] n);
         if (p <= flsc_pkg::KIND_COLUMN)
            return n == flsc_pkg::KIND_COMMA || n == flsc_pkg::KIND_CLOSE;
         if (p == flsc_pkg::KIND_FUNCTION) return n == flsc_pkg::KIND_OPEN;
         if (p == flsc_pkg::KIND_COMMA) return n <= flsc_pkg::KIND_FUNCTION;
         if (p == flsc_pkg::KIND_OPEN)
            return n <= flsc_pkg::KIND_FUNCTION || n == flsc_pkg::KIND_CLOSE;
         if (p == flsc_pkg::KIND_CLOSE)
            return n == flsc_pkg::KIND_COMMA || n == flsc_pkg::KIND_CLOSE ||
                   n == flsc_pkg::KIND_INVALID;
         return 1;
      endfunction

      function void push_token(bit [3:0] k);
         beat_type b;
         b = '{0, k, flsc_pkg::STATUS_OK, 0};
         pending_beats = {pending_beats, b};
         tokens++;
         if (k == flsc_pkg::KIND_INVALID) saw_invalid = 1;
         if (ntok == 0) first_k = k;
         else if (!grammar_bad && (back_to_zero || !may_follow(prev_k, k))) grammar_bad = 1;
         if (!grammar_bad) begin
            if (k == flsc_pkg::KIND_OPEN) begin
               if (depth >= DEPTH_LIMIT) grammar_bad = 1;
               else begin
                  depth++; opened = 1;
               end
            end else if (k == flsc_pkg::KIND_CLOSE) begin
               if (depth == 0) grammar_bad = 1;
               else begin
                  depth--;
                  if (depth == 0 && opened) back_to_zero = 1;
               end
            end
         end
         prev_k = k;
         if (ntok < 2) ntok++;
      endfunction

      function void flush_word();
         bit [3:0] k;
         if (!pend) return;
         case (lx)
            LX_INT: k = flsc_pkg::KIND_INT32;
            LX_INT64: k = flsc_pkg::KIND_INT64;
            LX_DOT, LX_FRAC: k = flsc_pkg::KIND_FLOAT64;
            LX_F32: k = flsc_pkg::KIND_FLOAT32;
            LX_COLUMN: k = flsc_pkg::KIND_COLUMN;
            LX_IDENT: k = (kw == 4 || kw == 9) ? flsc_pkg::KIND_BOOLEAN
                                               : flsc_pkg::KIND_FUNCTION;
            default: k = flsc_pkg::KIND_INVALID;
         endcase
         push_token(k);
         lx = LX_START; kw = 0; pend = 0;
      endfunction

      // keyword tracker for True / False
      function bit [3:0] keyword_step(bit [3:0] p, bit [7:0] c);
         bit [7:0] want;
         case (p)
            1: want = "r"; 2: want = "u"; 3: want = "e"; 5: want = "a";
            6: want = "l"; 7: want = "s"; 8: want = "e";
            default: want = 0;
         endcase
         if (want != 0 && want == c) return p + 4'd1;
         return 4'd0;
      endfunction

      function void lex_char(bit [7:0] c);
         bit [3:0] n;
         n = LX_BAD;
         case (lx)
            LX_START: begin
               if (c == "-") n = LX_MINUS;
               else if (digit(c)) n = LX_INT;
               else if (c == "$") n = LX_DOLLAR;
               else if (alpha(c)) begin
                  n = LX_IDENT;
                  kw = (c == "T") ? 4'd1 : (c == "F") ? 4'd5 : 4'd0;
               end
            end
            LX_MINUS: if (digit(c)) n = LX_INT;
            LX_INT: begin
               if (digit(c)) n = LX_INT;
               else if (c == "l" || c == "L") n = LX_INT64;
               else if (c == ".") n = LX_DOT;
            end
            LX_DOT, LX_FRAC: begin
               if (digit(c)) n = LX_FRAC;
               else if (c == "f") n = LX_F32;
            end
            LX_DOLLAR: if (alpha(c) || c == "_") n = LX_COLUMN;
            LX_COLUMN: if (wordc(c)) n = LX_COLUMN;
            LX_IDENT: if (wordc(c)) begin
               n = LX_IDENT; kw = keyword_step(kw, c);
            end
            default: ;
         endcase
         lx = n; pend = 1;
      endfunction

      function void take_char(bit [7:0] c);
         if (in_str) begin
            if (c == "\"") begin
               push_token(lx == LX_STR_BAD ? flsc_pkg::KIND_INVALID : flsc_pkg::KIND_STRING);
               in_str = 0; lx = LX_START; pend = 0;
            end else if (c == 8'h0d || c == 8'h0a) lx = LX_STR_BAD;
         end else if (c == "\"") begin
            flush_word();
            in_str = 1; lx = LX_STR; kw = 0; pend = 1;
         end else if (c == " " || c == ",") begin
            flush_word();
            if (c == ",") push_token(flsc_pkg::KIND_COMMA);
         end else if (c == "(" || c == ")") begin
            flush_word();
            push_token(c == "(" ? flsc_pkg::KIND_OPEN : flsc_pkg::KIND_CLOSE);
         end else lex_char(c);
      endfunction

      // notes one accepted character and queues the beats it causes
      function void note_char(bit [7:0] c, bit fin);
         int beats_at_start;
         bit [2:0] st;
         beat_type b;
         beats_at_start = pending_beats.size();
         take_char(c);
         if (fin) begin
            take_char(" ");
            if (in_str) st = flsc_pkg::STATUS_UNTERM;
            else if (saw_invalid) st = flsc_pkg::STATUS_INVALID;
            else if (ntok == 0) st = flsc_pkg::STATUS_EMPTY;
            else if (ntok == 1)
               st = (first_k <= flsc_pkg::KIND_COLUMN) ? flsc_pkg::STATUS_OK
                                                      : flsc_pkg::STATUS_LONE;
            else if (first_k != flsc_pkg::KIND_FUNCTION) st = flsc_pkg::STATUS_FIRST_FUNC;
            else if (grammar_bad || depth != 0) st = flsc_pkg::STATUS_SYNTAX;
            else st = flsc_pkg::STATUS_OK;
            b = '{1, flsc_pkg::KIND_INT32, st, 0};
            pending_beats = {pending_beats, b};
            statuses++;
            clear();
         end
         if (pending_beats.size() > beats_at_start)
            pending_beats[pending_beats.size() - 1].run_end = 1;
      endfunction

      function void check_beat(beat_type got);
         beat_type want;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected result beat %p", $realtime, got);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         if (got.is_status != want.is_status) begin
            $display("%0t: is_status expected %0d actual %0d", $realtime,
                     want.is_status, got.is_status);
            errors++;
         end
         if (got.kind != want.kind) begin
            $display("%0t: token_kind expected %0d actual %0d", $realtime, want.kind, got.kind);
            errors++;
         end
         if (got.status != want.status) begin
            $display("%0t: status_code expected %0d actual %0d", $realtime,
                     want.status, got.status);
            errors++;
         end
         if (got.run_end != want.run_end) begin
            $display("%0t: run_end expected %0d actual %0d", $realtime,
                     want.run_end, got.run_end);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_char_code = 0;
   logic       req_is_final = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic       rsp_is_status;
   logic [3:0] rsp_token_kind;
   logic [2:0] rsp_status_code;
   logic       rsp_run_end;

   formula_scoreboard sb;
   int  cycles = 0;
   bit  calm = 0;        // no idling in the closing stretch
   int  sent = 0;
   byte text[$];         // formula under construction

   formula_lexer_syntax_checker #(.MAX_DEPTH(DEPTH_LIMIT)) dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_formula_lexer_syntax_checker failed");
         $finish;
      end
   end

   // result side: random stall bursts, check every accepted beat
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_beat('{rsp_is_status, rsp_token_kind, rsp_status_code, rsp_run_end});
         if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 5) - 1;
            rsp_ready <= 0;
         end else rsp_ready <= 1;
      end
   end

   // sends one character and waits for acceptance, with an occasional gap first
   task automatic send_char(input byte c, input bit fin);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_char_code <= c;
      req_is_final <= fin;
      do @(posedge clock); while (!req_ready);
      sb.note_char(c, fin);
      sent++;
   endtask

   // sends the text built up so far as one formula, last character marked final
   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
      text.delete();
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text = {text, s[i]};
   endtask

   // one random token that is usually valid
   task automatic add_value();
      case ($urandom_range(0, 11))
         0: add_str($sformatf("%0d", $urandom_range(0, 99999)));
         1: add_str($sformatf("-%0dL", $urandom_range(0, 999)));
         2: add_str($sformatf("%0d.%0df", $urandom_range(0, 99), $urandom_range(0, 99)));
         3: add_str($sformatf("%0d.", $urandom_range(0, 9)));
         4: add_str($sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99)));
         5: add_str($urandom_range(0, 1) ? "True" : "False");
         6: add_str($urandom_range(0, 1) ? "$col_1" : "$_x");
         7: add_str("\"s t,()\"");
         8: add_str($urandom_range(0, 1) ? "Tru" : "Falsey");
         9: add_str("7l");
         10: text = {text, 8'($urandom_range(128, 255))};
         default: add_str("\"ab\"");
      endcase
   endtask

   // a nested call, mostly well formed
   task automatic add_call(input int lvl);
      int n;
      add_str($urandom_range(0, 1) ? "sum" : "Fn_2");
      if ($urandom_range(0, 1)) add_str(" ");
      add_str("(");
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         if (i > 0) add_str($urandom_range(0, 3) == 0 ? " , " : ",");
         if (lvl < 3 && $urandom_range(0, 3) == 0) add_call(lvl + 1);
         else add_value();
      end
      add_str(")");
   endtask

   task automatic random_formula();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) add_call(0);
      else if (r == 6) add_value();
      else begin
         // noise: random bytes, any value
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
               0: text = {text, 8'($urandom_range(0, 255))};
               1: add_str("(");
               2: add_str(")");
               default: add_str($urandom_range(0, 1) ? "\"" : ",");
            endcase
         end
      end
      // occasional corruption of a good call
      if (r < 6 && $urandom_range(0, 7) == 0 && text.size() > 1)
         text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      send_text();
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending_beats.size() != 0) @(posedge clock);
   endtask

   initial begin
      string directed[$];
      sb = new();
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every token kind, lone and empty cases, strings with line breaks
      directed = '{"f(1,2L,3.5f,-4.,\"x\",True,$c,g())", "42", "\"open", "",
                   "f(1))", "f()x", "1,2", "f(a\"b\")", ")"};
      foreach (directed[i]) begin
         if (directed[i].len() == 0) send_char(" ", 1);
         else begin
            add_str(directed[i]); send_text();
         end
      end
      add_str("f(\"a"); text = {text, 8'h0d}; add_str("\",\"b");
      text = {text, 8'h0a}; add_str("\")"); send_text();
      send_char(8'hff, 1);
      send_char(8'h00, 1);
      // pause until every expected beat is back
      drain();
      // depth overflow
      add_str("f");
      repeat (DEPTH_LIMIT + 1) add_str("(");
      send_text();

      while (sent < 410) begin
         if (sent > 360) calm = 1;
         random_formula();
      end
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d characters, %0d token beats, %0d formula status beats",
               sent, sb.tokens, sb.statuses);
      if (sb.errors == 0 && sb.pending_beats.size() == 0)
         $display("tb_formula_lexer_syntax_checker passed");
      else
         $display("tb_formula_lexer_syntax_checker failed");
      $finish;
   end
endmodule
